// ===== hw/rtl/mhsig_pkg.sv =====
// Shared types and constants for the MinHash signature block.
// No dependencies; imported by mhsig_cell, mhsig_ctrl and minhash_signature_top.
`default_nettype none

package mhsig_pkg;

    localparam int MAX_HASHES_DEF = 64;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 6;
    localparam int COEF_W  = 31;
    localparam int ELEM_W  = 32;
    localparam int ACT_W   = 7;
    localparam int PROD_W  = 63;
    localparam int WIDE_W  = 64;
    localparam int FOLD_W  = 34;

    // 2^31 - 1 and a multiple of it (M << 32) that lifts any a*x+b above zero
    localparam logic [COEF_W-1:0] MOD_PRIME  = 31'h7FFF_FFFF;
    localparam logic [WIDE_W-1:0] MOD_OFFSET = 64'h7FFF_FFFF_0000_0000;
    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ADD    = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    // request travelling down the cell row
    typedef struct packed {
        op_t                       op;
        logic [SLOT_W-1:0]         slot;
        logic [COEF_W-1:0]         coef_mul;
        logic [COEF_W-1:0]         coef_add;
        logic signed [ELEM_W-1:0]  element;
        logic [ACT_W-1:0]          active;
    } token_t;

    typedef struct packed {
        logic capture;   // move minima into the readout row, reset minima
        logic shift;     // readout row moves one cell toward slot 0
    } chain_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mhsig_cell.sv =====
// One hash slot: coefficient pair, four-stage a*x+b mod (2^31-1) pipe, running minimum.
// Depends on mhsig_pkg. Requests pass to the next cell every cycle.
`default_nettype none

module mhsig_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  mhsig_pkg::token_t                  in_tok,
    output logic                               out_valid,
    output mhsig_pkg::token_t                  out_tok,
    input  mhsig_pkg::chain_ctl_t              ctl,
    input  logic [mhsig_pkg::COEF_W-1:0]       shift_in,
    output logic [mhsig_pkg::COEF_W-1:0]       shift_out
);
    import mhsig_pkg::*;

    logic                      tok_valid_reg;
    token_t                    tok_reg;
    logic [COEF_W-1:0]         mul_reg;
    logic [COEF_W-1:0]         add_reg;

    logic                      v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [COEF_W-1:0]         pb_reg;
    logic [WIDE_W-1:0]         wide_reg, wide_next;
    logic [FOLD_W-1:0]         fold_reg, fold_next;
    logic [COEF_W-1:0]         min_reg, min_next;
    logic [COEF_W-1:0]         shift_reg, shift_next;

    logic                      hit_load, hit_add;
    logic signed [WIDE_W-1:0]  prod_full;
    logic [COEF_W:0]           sum2;
    logic [COEF_W-1:0]         hash;

    assign hit_load = tok_valid_reg && (tok_reg.op == OP_LOAD)
                      && (tok_reg.slot == SLOT_W'(CELL_INDEX));
    assign hit_add  = tok_valid_reg && (tok_reg.op == OP_ADD)
                      && (ACT_W'(CELL_INDEX) < tok_reg.active);

    // stage 1: signed product a*x
    assign prod_full = $signed({1'b0, mul_reg}) * tok_reg.element;
    assign prod_next = prod_full[PROD_W-1:0];

    // stage 2: + b + offset, always non-negative and below 2^64
    assign wide_next = {prod_reg[PROD_W-1], prod_reg} + {33'd0, pb_reg} + MOD_OFFSET;

    // stage 3: first Mersenne fold, 2^31 == 1
    assign fold_next = {1'b0, wide_reg[WIDE_W-1:COEF_W]} + {3'd0, wide_reg[COEF_W-1:0]};

    // stage 4: second fold, final correction, minimum
    assign sum2 = {29'd0, fold_reg[FOLD_W-1:COEF_W]} + {1'b0, fold_reg[COEF_W-1:0]};
    assign hash = (sum2 >= {1'b0, MOD_PRIME}) ? COEF_W'(sum2 - {1'b0, MOD_PRIME})
                                             : sum2[COEF_W-1:0];

    always_comb
    begin
        min_next = min_reg;
        if (ctl.capture)
        begin
            min_next = MOD_PRIME;
        end
        else if (v3_reg && (hash < min_reg))
        begin
            min_next = hash;
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        if (ctl.capture)
        begin
            shift_next = min_reg;
        end
        else if (ctl.shift)
        begin
            shift_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            min_reg       <= MOD_PRIME;
        end
        else
        begin
            tok_valid_reg <= in_valid;
            v1_reg        <= hit_add;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            min_reg       <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg   <= in_tok;
        prod_reg  <= prod_next;
        pb_reg    <= add_reg;
        wide_reg  <= wide_next;
        fold_reg  <= fold_next;
        shift_reg <= shift_next;
        if (hit_load)
        begin
            mul_reg <= tok_reg.coef_mul;
            add_reg <= tok_reg.coef_add;
        end
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;
    assign shift_out = shift_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mhsig_ctrl.sv =====
// Request decode, configuration register, finish sequencing and result registers.
// Depends on mhsig_pkg. Feeds the head of the cell row and reads its readout output.
`default_nettype none

module mhsig_ctrl #(
    parameter int MAX_HASHES = mhsig_pkg::MAX_HASHES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mhsig_pkg::OP_W-1:0]         operation,
    input  logic [mhsig_pkg::SLOT_W-1:0]       slot,
    input  logic [mhsig_pkg::COEF_W-1:0]       coef_mul,
    input  logic [mhsig_pkg::COEF_W-1:0]       coef_add,
    input  logic signed [mhsig_pkg::ELEM_W-1:0] element,
    input  logic                               cfg_we,
    input  logic [mhsig_pkg::ACT_W-1:0]        cfg_data,
    output logic                               entry_valid,
    output mhsig_pkg::token_t                  entry_tok,
    output mhsig_pkg::chain_ctl_t              ctl,
    input  logic [mhsig_pkg::COEF_W-1:0]       chain_head,
    output logic                               done,
    output logic [mhsig_pkg::SLOT_W-1:0]       out_slot,
    output logic [mhsig_pkg::COEF_W-1:0]       min_value,
    output logic                               empty_error,
    output logic                               last
);
    import mhsig_pkg::*;

    // the last add must reach the far cell's minimum before the drain ends and the minima are captured
    localparam int DRAIN_CYCLES = MAX_HASHES + 4;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    ctrl_state_t          state_reg, state_next;
    logic [ACT_W-1:0]     active_reg;
    logic [ACT_W-1:0]     n_reg, n_cur;
    logic                 any_elem_reg;
    logic [DRAIN_W-1:0]   drain_reg;
    logic [SLOT_W-1:0]    emit_idx_reg;

    logic                 done_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [COEF_W-1:0]    min_value_reg;
    logic                 empty_error_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 is_load, is_add, is_finish;
    logic                 emit_last;
    logic                 empty_finish;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        is_load   = 1'b0;
        is_add    = 1'b0;
        is_finish = 1'b0;
        unique case (operation)
            OP_LOAD:   is_load   = 1'b1;
            OP_ADD:    is_add    = 1'b1;
            OP_FINISH: is_finish = 1'b1;
            default:   ;
        endcase
    end

    always_comb
    begin
        if (active_reg == '0)
        begin
            n_cur = ACT_W'(1);
        end
        else if (active_reg > ACT_W'(MAX_HASHES))
        begin
            n_cur = ACT_W'(MAX_HASHES);
        end
        else
        begin
            n_cur = active_reg;
        end
    end

    assign empty_finish = accept && is_finish && !any_elem_reg;
    assign emit_last    = ((ACT_W'(emit_idx_reg) + ACT_W'(1)) == n_reg);

    // head of the row
    assign entry_valid        = accept && (is_load || is_add);
    assign entry_tok.op       = op_t'(operation);
    assign entry_tok.slot     = slot;
    assign entry_tok.coef_mul = coef_mul;
    assign entry_tok.coef_add = coef_add;
    assign entry_tok.element  = element;
    assign entry_tok.active   = n_cur;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_finish && any_elem_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        ctl.capture = 1'b0;
        ctl.shift   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_DRAIN: ctl.capture = (drain_reg == '0);
            ST_EMIT:  ctl.shift = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= ACTIVE_RESET;
            any_elem_reg <= 1'b0;
            drain_reg    <= '0;
            emit_idx_reg <= '0;
            n_reg        <= ACT_W'(1);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (accept && is_add)
            begin
                any_elem_reg <= 1'b1;
            end
            else if (accept && is_finish)
            begin
                any_elem_reg <= 1'b0;
            end
            if (accept && is_finish)
            begin
                drain_reg <= DRAIN_W'(DRAIN_CYCLES - 1);
                n_reg     <= n_cur;
            end
            else if (state_reg == ST_DRAIN)
            begin
                drain_reg <= drain_reg - DRAIN_W'(1);
            end
            if (ctl.capture)
            begin
                emit_idx_reg <= '0;
            end
            else if (ctl.shift)
            begin
                emit_idx_reg <= emit_idx_reg + SLOT_W'(1);
            end
            done_reg <= ctl.shift || empty_finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            out_slot_reg    <= emit_idx_reg;
            min_value_reg   <= chain_head;
            empty_error_reg <= 1'b0;
            last_reg        <= emit_last;
        end
        else if (empty_finish)
        begin
            out_slot_reg    <= '0;
            min_value_reg   <= '0;
            empty_error_reg <= 1'b1;
            last_reg        <= 1'b1;
        end
    end

    assign done        = done_reg;
    assign out_slot    = out_slot_reg;
    assign min_value   = min_value_reg;
    assign empty_error = empty_error_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_error |-> last)
        else $error("empty error result not flagged last");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("block still busy on the final result");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && (out_slot == $past(out_slot) + SLOT_W'(1)))
        else $error("signature words not contiguous");

    a_finish_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_FINISH) && any_elem_reg |=> busy && !done)
        else $error("non-empty finish did not start the drain");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/minhash_signature_top.sv =====
// MinHash signature top level: controller plus a row of MAX_HASHES hash cells.
// Depends on mhsig_pkg, mhsig_cell and mhsig_ctrl.
// Load and add requests: one per cycle, back to back, while busy is low; they do not raise busy.
// Finish (non-empty): busy through a drain of the cell row and then an emit phase of n
//   results, n = active_hashes clamped to 1..MAX_HASHES, given out one per cycle.
//   Drain length is set by the cell row.
// Finish (empty): one error result the next cycle, no busy time.
// Results cannot be stalled. Reset: minima to 2^31-1, active_hashes to 64; coefficients not reset.
`default_nettype none

module minhash_signature_top #(
    parameter int MAX_HASHES = mhsig_pkg::MAX_HASHES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [mhsig_pkg::OP_W-1:0]          operation,
    input  logic [mhsig_pkg::SLOT_W-1:0]        slot,
    input  logic [mhsig_pkg::COEF_W-1:0]        coef_mul,
    input  logic [mhsig_pkg::COEF_W-1:0]        coef_add,
    input  logic signed [mhsig_pkg::ELEM_W-1:0] element,
    // active_hashes register
    input  logic                                cfg_we,
    input  logic [mhsig_pkg::ACT_W-1:0]         cfg_data,
    // result channel, one-cycle strobe
    output logic                                done,
    output logic [mhsig_pkg::SLOT_W-1:0]        out_slot,
    output logic [mhsig_pkg::COEF_W-1:0]        min_value,
    output logic                                empty_error,
    output logic                                last
);
    import mhsig_pkg::*;

    // Requests enter cell 0 and walk one cell per cycle; each cell runs its
    // own a*x+b mod (2^31-1) pipe, so adds need not wait for each other.
    // Finish waits until the last add has left the far cell's pipe, copies
    // every minimum into a readout row and streams it out through cell 0.
    logic                 tok_valid [0:MAX_HASHES];
    token_t               tok_chain [0:MAX_HASHES];
    logic [COEF_W-1:0]    rd_chain  [0:MAX_HASHES];
    chain_ctl_t           ctl;

    mhsig_ctrl #(
        .MAX_HASHES (MAX_HASHES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .slot        (slot),
        .coef_mul    (coef_mul),
        .coef_add    (coef_add),
        .element     (element),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .entry_valid (tok_valid[0]),
        .entry_tok   (tok_chain[0]),
        .ctl         (ctl),
        .chain_head  (rd_chain[0]),
        .done        (done),
        .out_slot    (out_slot),
        .min_value   (min_value),
        .empty_error (empty_error),
        .last        (last)
    );

    // readout row end: nothing beyond the last slot
    assign rd_chain[MAX_HASHES] = MOD_PRIME;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HASHES; gi++)
        begin : g_cell
            mhsig_cell #(
                .CELL_INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (tok_valid[gi]),
                .in_tok    (tok_chain[gi]),
                .out_valid (tok_valid[gi+1]),
                .out_tok   (tok_chain[gi+1]),
                .ctl       (ctl),
                .shift_in  (rd_chain[gi+1]),
                .shift_out (rd_chain[gi])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// ===== tb/tb_minhash_signature_top.sv =====
// Self-checking testbench for minhash_signature_top: coefficient loads, element adds and
// signature readout, checked against an in-bench signature predictor.
// Depends on mhsig_pkg and minhash_signature_top (with its cells and controller).
`default_nettype none

module tb_minhash_signature_top;

    import mhsig_pkg::*;

    localparam int NSLOT       = MAX_HASHES_DEF;
    // Finish drains the cell row before results come out;
    // an add may still be travelling down the row when nothing is expected.
    localparam int SETTLE_CYC  = NSLOT + 8;
    // Upper bound on the whole run; the watchdog reports FAIL when it is reached.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RAND_ITEMS  = 430;
    localparam int N_PHASES    = 8;

    // the one operation code the package leaves out; the block ignores it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [SLOT_W-1:0]        slot;
        logic [COEF_W-1:0]        mul;
        logic [COEF_W-1:0]        add;
        logic signed [ELEM_W-1:0] element;
    } request_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [COEF_W-1:0] min_value;
        logic              empty_error;
        logic              is_last;
    } sig_word_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          operation   = '0;
    logic [SLOT_W-1:0]        slot        = '0;
    logic [COEF_W-1:0]        coef_mul    = '0;
    logic [COEF_W-1:0]        coef_add    = '0;
    logic signed [ELEM_W-1:0] element     = '0;
    logic                     cfg_we      = 1'b0;
    logic [ACT_W-1:0]         cfg_data    = ACTIVE_RESET;
    logic                     done;
    logic [SLOT_W-1:0]        out_slot;
    logic [COEF_W-1:0]        min_value;
    logic                     empty_error;
    logic                     last;

    minhash_signature_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .slot        (slot),
        .coef_mul    (coef_mul),
        .coef_add    (coef_add),
        .element     (element),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .out_slot    (out_slot),
        .min_value   (min_value),
        .empty_error (empty_error),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the coefficient tables, minima and
    // the active_hashes register
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] mul_tab [NSLOT];
    logic [COEF_W-1:0] add_tab [NSLOT];
    logic [COEF_W-1:0] min_tab [NSLOT];
    logic              seen_element;
    logic [ACT_W-1:0]  active_cfg = ACTIVE_RESET;

    // stimulus-side bookkeeping: which slots hold coefficients
    logic              coef_ready [NSLOT];

    request_t  pending_requests [$];
    sig_word_t sig_words_due    [$];
    request_t  cur_req;

    int  stim_count  = 0;
    int  fail_count  = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    int  gap_left    = 0;
    bit  gaps_on     = 1'b1;

    // 0 behaves as 1, anything above the row length as the row length
    function automatic int eff_active(input logic [ACT_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > NSLOT)
            return NSLOT;
        return int'(v);
    endfunction

    // (a*x + b) mod (2^31-1), exact, residue non-negative
    function automatic logic [COEF_W-1:0] slot_residue(input logic [COEF_W-1:0] a,
                                                       input logic [COEF_W-1:0] b,
                                                       input logic signed [ELEM_W-1:0] x);
        longint prod;
        longint rem;
        prod = longint'(a) * longint'(x) + longint'(b);
        rem  = prod % longint'(MOD_PRIME);
        if (rem < 0)
            rem += longint'(MOD_PRIME);
        return rem[COEF_W-1:0];
    endfunction

    function automatic void clear_minima();
        for (int i = 0; i < NSLOT; i++)
            min_tab[i] = MOD_PRIME;
        seen_element = 1'b0;
    endfunction

    // Advance the signature predictor by one accepted request and queue the
    // signature words it produces.
    function automatic void apply_to_signature(input request_t r);
        int          n;
        logic [COEF_W-1:0] h;
        sig_word_t   w;
        n = eff_active(active_cfg);
        case (r.op)
            OP_LOAD:
            begin
                mul_tab[r.slot] = r.mul;
                add_tab[r.slot] = r.add;
            end
            OP_ADD:
            begin
                for (int i = 0; i < n; i++)
                begin
                    h = slot_residue(mul_tab[i], add_tab[i], r.element);
                    if (h < min_tab[i])
                        min_tab[i] = h;
                end
                seen_element = 1'b1;
            end
            OP_FINISH:
            begin
                if (!seen_element)
                begin
                    // empty set: one error word
                    w = '{slot: '0, min_value: '0, empty_error: 1'b1, is_last: 1'b1};
                    sig_words_due.insert(sig_words_due.size(), w);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        w.slot        = SLOT_W'(i);
                        w.min_value   = min_tab[i];
                        w.empty_error = 1'b0;
                        w.is_last     = (i == n - 1);
                        sig_words_due.insert(sig_words_due.size(), w);
                    end
                end
                clear_minima();
            end
            default: ;  // unused code: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents requests from the pending queue in bursts with
    // random gaps (when gaps_on is set); a request is taken at an edge with start high, busy low
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= '0;
            slot      <= '0;
            coef_mul  <= '0;
            coef_add  <= '0;
            element   <= '0;
        end
        else if (!start || !busy)
        begin
            // start high here means the current request went in at this edge
            if (start)
                apply_to_signature(cur_req);
            if (gap_left > 0 || pending_requests.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                cur_req = pending_requests.pop_front();
                start     <= 1'b1;
                operation <= cur_req.op;
                slot      <= cur_req.slot;
                coef_mul  <= cur_req.mul;
                coef_add  <= cur_req.add;
                element   <= cur_req.element;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = gaps_on ? $urandom_range(1, 8) : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be held off, so every strobe is checked
    // against the oldest predicted signature word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sig_word_t want;
        if (rst_n && done)
        begin
            if (sig_words_due.size() == 0)
            begin
                $error("unexpected result: out_slot %0d min_value %0d empty_error %0b last %0b",
                       out_slot, min_value, empty_error, last);
                fail_count++;
            end
            else
            begin
                want = sig_words_due.pop_front();
                if (out_slot !== want.slot)
                begin
                    $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
                    fail_count++;
                end
                if (min_value !== want.min_value)
                begin
                    $error("min_value: expected %0d, got %0d", want.min_value, min_value);
                    fail_count++;
                end
                if (empty_error !== want.empty_error)
                begin
                    $error("empty_error: expected %0b, got %0b", want.empty_error, empty_error);
                    fail_count++;
                end
                if (last !== want.is_last)
                begin
                    $error("last: expected %0b, got %0b", want.is_last, last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_minhash_signature_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 31'd1;
            1:       return MOD_PRIME;
            default: return COEF_W'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return ELEM_W'($urandom_range(0, 15));
            3:       return -ELEM_W'($urandom_range(1, 15));
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic void push_req(input request_t r);
        pending_requests.insert(pending_requests.size(), r);
        if (r.op != OP_UNUSED)
            stim_count++;
    endfunction

    function automatic void push_load(input int s, input logic [COEF_W-1:0] a,
                                      input logic [COEF_W-1:0] b);
        request_t r;
        r.op      = OP_LOAD;
        r.slot    = SLOT_W'(s);
        r.mul     = a;
        r.add     = b;
        r.element = ELEM_W'($urandom);  // don't-care field, keep it noisy
        coef_ready[s] = 1'b1;
        push_req(r);
    endfunction

    // Never let an add read a slot whose coefficients were not loaded:
    // fill any gap among the active slots first.
    function automatic void push_add(input logic signed [ELEM_W-1:0] x);
        request_t r;
        for (int i = 0; i < eff_active(active_cfg); i++)
            if (!coef_ready[i])
                push_load(i, pick_coef(), pick_coef());
        r.op      = OP_ADD;
        r.slot    = SLOT_W'($urandom);
        r.mul     = COEF_W'($urandom);
        r.add     = COEF_W'($urandom);
        r.element = x;
        push_req(r);
    endfunction

    function automatic void push_finish();
        request_t r;
        r.op      = OP_FINISH;
        r.slot    = SLOT_W'($urandom);
        r.mul     = COEF_W'($urandom);
        r.add     = COEF_W'($urandom);
        r.element = ELEM_W'($urandom);
        push_req(r);
    endfunction

    function automatic void push_noise();
        request_t r;
        r.op      = OP_UNUSED;
        r.slot    = SLOT_W'($urandom);
        r.mul     = COEF_W'($urandom);
        r.add     = COEF_W'($urandom);
        r.element = ELEM_W'($urandom);
        push_req(r);
    endfunction

    // Mostly complete runs (loads, adds, finish) with random content; the
    // rest is stray finishes, stray loads, ignored codes and runs left open.
    function automatic void push_sequence();
        int kind;
        kind = $urandom_range(0, 15);
        if (kind == 0)
            push_noise();
        else if (kind == 1)
            push_finish();          // usually lands on an empty set
        else if (kind == 2)
            repeat ($urandom_range(1, 3))
                push_load($urandom_range(0, NSLOT - 1), pick_coef(), pick_coef());
        else
        begin
            repeat ($urandom_range(0, 2))
                push_load($urandom_range(0, NSLOT - 1), pick_coef(), pick_coef());
            repeat ($urandom_range(1, 16))
            begin
                // occasional reload of a slot in the middle of a run
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, NSLOT - 1), pick_coef(), pick_coef());
                push_add(pick_element());
            end
            if (kind != 3)
                push_finish();      // kind 3 leaves the set open into what follows
        end
    endfunction

    // Block is idle once the queue is drained, start is low and nothing is due;
    // the extra wait lets any add still in the cell row land.
    task automatic wait_idle(input int extra);
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || sig_words_due.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        active_cfg = v;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [ACT_W-1:0] act_plan [N_PHASES];
        int               phase_goal;

        for (int i = 0; i < NSLOT; i++)
        begin
            mul_tab[i]    = '0;
            add_tab[i]    = '0;
            coef_ready[i] = 1'b0;
        end
        clear_minima();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part: one active slot ---
        write_active(7'd1);
        push_finish();                              // empty set -> error word
        push_noise();                               // ignored code
        push_load(0, MOD_PRIME, MOD_PRIME);         // largest coefficients
        push_add(32'sh7FFF_FFFF);
        push_add(32'sh8000_0000);
        push_add(32'sh0000_0000);
        push_add(-32'sd1);
        push_finish();
        push_finish();                              // state was cleared -> empty again
        push_load(0, 31'd1, 31'd1);                 // smallest coefficients
        push_load(NSLOT - 1, 31'd1, MOD_PRIME);     // top slot, not active yet
        push_load(1, MOD_PRIME, 31'd1);
        push_add(-32'sd1);                          // residue 0 in slot 0
        push_finish();
        push_add(32'sd12345);                       // updates slot 0 only
        wait_idle(SETTLE_CYC);

        // widen while a set is open: slot 1 was never updated, reads all ones
        write_active(7'd2);
        push_finish();
        wait_idle(SETTLE_CYC);

        // zero behaves as one active slot
        write_active(7'd0);
        push_add(32'sd5);
        push_finish();
        wait_idle(SETTLE_CYC);

        // --- random part ---
        act_plan[0] = 7'd64;
        act_plan[1] = 7'd127;                       // above the row length
        act_plan[2] = 7'd0;
        act_plan[3] = 7'd1;
        act_plan[4] = ACT_W'($urandom_range(2, NSLOT - 1));
        act_plan[5] = ACT_W'($urandom_range(0, 127));
        act_plan[6] = 7'd64;
        act_plan[7] = ACT_W'($urandom_range(1, NSLOT));

        stim_count = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_active(act_plan[p]);
            gaps_on    = (p % 3 != 2);              // every third phase runs back to back
            phase_goal = RAND_ITEMS * (p + 1) / N_PHASES;

            // first half, ending on a finish, then hold off until it drains
            while (stim_count < phase_goal - (RAND_ITEMS / N_PHASES) / 2)
                push_sequence();
            push_finish();
            wait_idle(0);

            while (stim_count < phase_goal)
                push_sequence();
            wait_idle(SETTLE_CYC);
        end

        if (fail_count == 0 && sig_words_due.size() == 0)
            $display("tb_minhash_signature_top: PASS");
        else
            $display("tb_minhash_signature_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
